// ===== hdl/crc8rx_pkg.sv =====
// Package for the CRC-8 packet receiver: transaction types, codes, CRC step.
// No dependencies.
`default_nettype none
package crc8rx_pkg;

  localparam logic [7:0]  START_BYTE = 8'h3E;
  localparam logic [7:0]  CRC_POLY   = 8'h07;
  localparam int          QUEUE_DEPTH = 4;
  localparam logic [16:0] TICK_MAX   = 17'h1FFFF;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_HDR_CRC  = 3'd1;
  localparam logic [2:0] ST_HDR_TO   = 3'd2;
  localparam logic [2:0] ST_PAY_ERR  = 3'd3;
  localparam logic [2:0] ST_SILENCE  = 3'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] REG_STATION_ID   = 2'd0;
  localparam logic [1:0] REG_BYTE_TO      = 2'd1;
  localparam logic [1:0] REG_SILENCE_TO   = 2'd2;
  localparam logic [1:0] REG_SILENCE_EN   = 2'd3;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] status;
    logic [7:0] source_id;
    logic [7:0] command;
    logic [7:0] payload_len;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
  } out_item_t;

  typedef struct packed {
    logic       is_tick;
    logic       is_start;
    logic [7:0] data;
  } q_item_t;

  typedef struct packed {
    logic [7:0]  station_id;
    logic [15:0] byte_timeout;
    logic [15:0] silence_timeout;
    logic        silence_enable;
  } cfg_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/crc8rx_front.sv =====
// Front end: accepts input transactions, tags ticks and start bytes, queues them.
// Depends on crc8rx_pkg.
`default_nettype none
module crc8rx_front import crc8rx_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_ready,
  input  wire in_item_t item,
  output logic          q_valid,
  input  wire logic     q_ready,
  output q_item_t       q_head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_item_t        slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;
  q_item_t        cls_item;

  assign item_ready = (count != CW'(DEPTH));
  assign q_valid    = (count != '0);
  assign push       = item_valid && item_ready;
  assign pop        = q_valid && q_ready;
  assign q_head     = slots[rd_ptr];

  always_comb begin
    cls_item.is_tick  = (item.cmd == CMD_TICK);
    cls_item.is_start = (item.rx_byte == START_BYTE);
    cls_item.data     = item.rx_byte;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count overflow");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("push lost");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1) else $error("pop lost");

endmodule
`default_nettype wire

// ===== hdl/crc8rx_back.sv =====
// Back end: packet state machine, CRC checks, timeouts and the result register.
// Depends on crc8rx_pkg.
`default_nettype none
module crc8rx_back import crc8rx_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  input  wire logic    q_valid,
  output logic         q_ready,
  input  wire q_item_t q_head,
  output logic         result_valid,
  input  wire logic    result_ready,
  output out_item_t    result
);

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAY_CRC = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  logic [1:0]  phase, phase_next;
  logic [16:0] tick_count, tick_count_next;
  logic [2:0]  header_index, header_index_next;
  logic [7:0]  header_crc_rx, header_crc_rx_next;
  logic [7:0]  dest_byte, dest_byte_next;
  logic [7:0]  src_byte, src_byte_next;
  logic [7:0]  cmd_byte, cmd_byte_next;
  logic [7:0]  len_byte, len_byte_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [7:0]  payload_crc_rx, payload_crc_rx_next;
  logic [7:0]  payload_count, payload_count_next;

  logic        fire;
  logic        emit;
  out_item_t   res_next;
  logic [16:0] tick_inc;
  logic [7:0]  crc_upd;
  logic        pending;

  assign q_ready  = !result_valid || result_ready;
  assign fire     = q_valid && q_ready;
  assign tick_inc = (tick_count == TICK_MAX) ? tick_count : tick_count + 1'b1;
  assign crc_upd  = crc8_step(running_crc, q_head.data);
  assign pending  = (phase == PH_PAYLOAD) && (payload_count == len_byte);

  always_comb begin
    phase_next          = phase;
    tick_count_next     = tick_count;
    header_index_next   = header_index;
    header_crc_rx_next  = header_crc_rx;
    dest_byte_next      = dest_byte;
    src_byte_next       = src_byte;
    cmd_byte_next       = cmd_byte;
    len_byte_next       = len_byte;
    running_crc_next    = running_crc;
    payload_crc_rx_next = payload_crc_rx;
    payload_count_next  = payload_count;
    emit                = 1'b0;
    res_next            = '0;

    if (pending) begin
      emit               = 1'b1;
      res_next.kind      = KIND_STATUS;
      res_next.status    = (running_crc == payload_crc_rx) ? ST_OK : ST_PAY_ERR;
      res_next.source_id = src_byte;
      res_next.command   = cmd_byte;
      res_next.payload_len = len_byte;
      phase_next         = PH_HUNT;
      tick_count_next    = '0;
      if (!q_head.is_tick && q_head.is_start) begin
        phase_next        = PH_HEADER;
        header_index_next = '0;
        running_crc_next  = '0;
      end
    end else if (q_head.is_tick) begin
      tick_count_next = tick_inc;
      if (phase == PH_HUNT) begin
        if (cfg.silence_enable && tick_inc > {1'b0, cfg.silence_timeout}) begin
          tick_count_next = '0;
          emit            = 1'b1;
          res_next.kind   = KIND_STATUS;
          res_next.status = ST_SILENCE;
        end
      end else if (tick_inc > {1'b0, cfg.byte_timeout}) begin
        phase_next      = PH_HUNT;
        tick_count_next = '0;
        emit            = 1'b1;
        res_next.kind   = KIND_STATUS;
        if (phase == PH_HEADER) begin
          res_next.status = ST_HDR_TO;
        end else begin
          res_next.status      = ST_PAY_ERR;
          res_next.source_id   = src_byte;
          res_next.command     = cmd_byte;
          res_next.payload_len = len_byte;
        end
      end
    end else begin
      unique case (phase)
        PH_HUNT: begin
          tick_count_next = '0;
          if (q_head.is_start) begin
            phase_next        = PH_HEADER;
            header_index_next = '0;
            running_crc_next  = '0;
          end
        end
        PH_HEADER: begin
          case (header_index)
            3'd0:    header_crc_rx_next = q_head.data;
            3'd1:    dest_byte_next     = q_head.data;
            3'd2:    src_byte_next      = q_head.data;
            3'd3:    cmd_byte_next      = q_head.data;
            default: len_byte_next      = q_head.data;
          endcase
          if (header_index != 3'd0) begin
            running_crc_next = crc_upd;
          end
          if (header_index < 3'd4) begin
            header_index_next = header_index + 1'b1;
          end else begin
            header_index_next = '0;
            tick_count_next   = '0;
            phase_next        = PH_HUNT;
            if (crc_upd != header_crc_rx) begin
              emit            = 1'b1;
              res_next.kind   = KIND_STATUS;
              res_next.status = ST_HDR_CRC;
            end else if (dest_byte != cfg.station_id) begin
              phase_next = PH_HUNT;
            end else if (q_head.data == 8'd0) begin
              emit                 = 1'b1;
              res_next.kind        = KIND_STATUS;
              res_next.status      = ST_OK;
              res_next.source_id   = src_byte;
              res_next.command     = cmd_byte;
              res_next.payload_len = q_head.data;
            end else begin
              phase_next = PH_PAY_CRC;
            end
          end
        end
        PH_PAY_CRC: begin
          payload_crc_rx_next = q_head.data;
          running_crc_next    = '0;
          payload_count_next  = '0;
          phase_next          = PH_PAYLOAD;
          tick_count_next     = '0;
        end
        default: begin
          emit                   = 1'b1;
          res_next.kind          = KIND_PAYLOAD;
          res_next.status        = ST_OK;
          res_next.source_id     = src_byte;
          res_next.command       = cmd_byte;
          res_next.payload_len   = len_byte;
          res_next.payload_byte  = q_head.data;
          res_next.payload_index = payload_count;
          running_crc_next       = crc_upd;
          payload_count_next     = payload_count + 1'b1;
          tick_count_next        = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      tick_count     <= '0;
      header_index   <= '0;
      header_crc_rx  <= '0;
      dest_byte      <= '0;
      src_byte       <= '0;
      cmd_byte       <= '0;
      len_byte       <= '0;
      running_crc    <= '0;
      payload_crc_rx <= '0;
      payload_count  <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (fire) begin
        phase          <= phase_next;
        tick_count     <= tick_count_next;
        header_index   <= header_index_next;
        header_crc_rx  <= header_crc_rx_next;
        dest_byte      <= dest_byte_next;
        src_byte       <= src_byte_next;
        cmd_byte       <= cmd_byte_next;
        len_byte       <= len_byte_next;
        running_crc    <= running_crc_next;
        payload_crc_rx <= payload_crc_rx_next;
        payload_count  <= payload_count_next;
      end
      if (fire && emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      result <= res_next;
    end
  end

  a_payload_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD || phase == PH_PAY_CRC) |-> len_byte != 8'd0)
    else $error("payload phase with zero length");

  a_header_index_bound: assert property (@(posedge clk) disable iff (rst)
    header_index <= 3'd4) else $error("header index out of range");

  a_payload_index: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KIND_PAYLOAD |->
      result.payload_index < result.payload_len && result.status == ST_OK)
    else $error("bad payload result");

  a_no_emit_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

// ===== hdl/crc8_packet_receiver_top.sv =====
// Top level of the CRC-8 packet receiver: APB registers, front queue, back engine.
// Depends on crc8rx_pkg, crc8rx_front, crc8rx_back.
//
//   channel  | handshake                 | payload
//   item     | item_valid / item_ready   | item (in_item_t: cmd, rx_byte)
//   result   | result_valid/result_ready | result (out_item_t)
//   config   | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// One transaction per cycle sustained while results are taken; the back engine
// handles one queued item per cycle, unless a stalled result holds it, with a
// single byte-wide CRC step. An item waits in a queue slot; its result is registered.
// Synchronous reset clears the queue, packet state and result valid; no clearing pass.
// A stalled result holds the back engine, and the front queue absorbs DEPTH items.
`default_nettype none
module crc8_packet_receiver_top import crc8rx_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire in_item_t    item,
  output logic             result_valid,
  input  wire logic        result_ready,
  output out_item_t        result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t    cfg;
  logic    q_valid;
  logic    q_ready;
  q_item_t q_head;
  logic    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.station_id      <= 8'd0;
      cfg.byte_timeout    <= 16'd100;
      cfg.silence_timeout <= 16'd1000;
      cfg.silence_enable  <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_STATION_ID: cfg.station_id      <= pwdata[7:0];
        REG_BYTE_TO:    cfg.byte_timeout    <= pwdata[15:0];
        REG_SILENCE_TO: cfg.silence_timeout <= pwdata[15:0];
        REG_SILENCE_EN: cfg.silence_enable  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_STATION_ID: prdata = {24'd0, cfg.station_id};
      REG_BYTE_TO:    prdata = {16'd0, cfg.byte_timeout};
      REG_SILENCE_TO: prdata = {16'd0, cfg.silence_timeout};
      REG_SILENCE_EN: prdata = {31'd0, cfg.silence_enable};
      default:        prdata = '0;
    endcase
  end

  crc8rx_front #(.DEPTH(DEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_head     (q_head)
  );

  crc8rx_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_head       (q_head),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire

// ===== test/crc8_packet_receiver_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for crc8_packet_receiver_top: directed frames, then random traffic.
// Depends on crc8rx_pkg and the receiver RTL; results are checked against a local frame model.
module crc8_packet_receiver_top_tb;
  import crc8rx_pkg::*;

  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 110;
  localparam int SETTLE_CYCLES  = 12;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum logic [1:0] {RX_HUNT, RX_HEADER, RX_PCRC, RX_PAYLOAD} rx_phase_e;

  typedef struct packed {
    in_item_t  it;
    logic      fixed;
    out_item_t res;
  } feed_entry_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  in_item_t    item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  out_item_t   result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  crc8_packet_receiver_top dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  feed_entry_t pending_items[$];
  out_item_t   expected_results[$];
  int          errors = 0;
  int          phase_items = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_ticket = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  // frame model: configuration
  logic [7:0]  m_station;
  logic [15:0] m_byte_to;
  logic [15:0] m_silence_to;
  logic        m_silence_en;
  // frame model: state
  rx_phase_e   ph;
  logic [16:0] ticks;
  logic [2:0]  hdr_idx;
  logic [7:0]  hdr_crc, hdr_dst, hdr_src, hdr_cmd, hdr_len;
  logic [7:0]  crc_acc, pay_crc, pay_count;

  // CRC-8 SMBus, one input bit at a time, MSB first
  function automatic logic [7:0] crc8_smbus(input logic [7:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic logic [7:0] header_crc(input logic [7:0] d, s, c, l);
    return crc8_smbus(crc8_smbus(crc8_smbus(crc8_smbus(8'h00, d), s), c), l);
  endfunction

  function automatic out_item_t status_result(input logic [2:0] st,
                                              input logic [7:0] src, cmd, len);
    out_item_t r;
    r = '0;
    r.kind = KIND_STATUS;
    r.status = st;
    r.source_id = src;
    r.command = cmd;
    r.payload_len = len;
    return r;
  endfunction

  function automatic out_item_t payload_result(input logic [7:0] src, cmd, len, b, idx);
    out_item_t r;
    r = status_result(ST_OK, src, cmd, len);
    r.kind = KIND_PAYLOAD;
    r.payload_byte = b;
    r.payload_index = idx;
    return r;
  endfunction

  function automatic void model_reset();
    m_station = 8'h00;
    m_byte_to = 16'd100;
    m_silence_to = 16'd1000;
    m_silence_en = 1'b0;
    ph = RX_HUNT;
    ticks = '0;
    hdr_idx = '0;
    {hdr_crc, hdr_dst, hdr_src, hdr_cmd, hdr_len} = '0;
    {crc_acc, pay_crc, pay_count} = '0;
  endfunction

  function automatic void hunt_on(input logic [7:0] b);
    ticks = '0;
    if (b == START_BYTE) begin
      ph = RX_HEADER;
      hdr_idx = '0;
      crc_acc = '0;
    end
  endfunction

  // Advances the frame model by one transaction; returns 1 when a result is due.
  function automatic bit deframe_step(input in_item_t it, output out_item_t res);
    bit         tick;
    logic [7:0] b;
    tick = (it.cmd == CMD_TICK);
    b = it.rx_byte;
    res = '0;
    // status of a finished payload goes out on the next transaction
    if (ph == RX_PAYLOAD && pay_count == hdr_len) begin
      res = status_result((crc_acc == pay_crc) ? ST_OK : ST_PAY_ERR, hdr_src, hdr_cmd, hdr_len);
      ph = RX_HUNT;
      ticks = '0;
      if (!tick) hunt_on(b);
      return 1;
    end
    if (tick) begin
      if (ticks != TICK_MAX) ticks++;
      if (ph == RX_HUNT) begin
        if (m_silence_en && ticks > m_silence_to) begin
          ticks = '0;
          res = status_result(ST_SILENCE, 8'h00, 8'h00, 8'h00);
          return 1;
        end
        return 0;
      end
      if (ticks > m_byte_to) begin
        if (ph == RX_HEADER) res = status_result(ST_HDR_TO, 8'h00, 8'h00, 8'h00);
        else res = status_result(ST_PAY_ERR, hdr_src, hdr_cmd, hdr_len);
        ph = RX_HUNT;
        ticks = '0;
        return 1;
      end
      return 0;
    end
    case (ph)
      RX_HUNT: begin
        hunt_on(b);
        return 0;
      end
      RX_HEADER: begin
        case (hdr_idx)
          3'd0: hdr_crc = b;
          3'd1: hdr_dst = b;
          3'd2: hdr_src = b;
          3'd3: hdr_cmd = b;
          default: hdr_len = b;
        endcase
        if (hdr_idx != 0) crc_acc = crc8_smbus(crc_acc, b);
        if (hdr_idx < 4) begin
          hdr_idx++;
          return 0;
        end
        hdr_idx = '0;
        ph = RX_HUNT;
        ticks = '0;
        if (crc_acc != hdr_crc) begin
          res = status_result(ST_HDR_CRC, 8'h00, 8'h00, 8'h00);
          return 1;
        end
        if (hdr_dst != m_station) return 0;
        if (hdr_len == 0) begin
          res = status_result(ST_OK, hdr_src, hdr_cmd, hdr_len);
          return 1;
        end
        ph = RX_PCRC;
        return 0;
      end
      RX_PCRC: begin
        pay_crc = b;
        crc_acc = '0;
        pay_count = '0;
        ph = RX_PAYLOAD;
        ticks = '0;
        return 0;
      end
      default: begin
        res = payload_result(hdr_src, hdr_cmd, hdr_len, b, pay_count);
        crc_acc = crc8_smbus(crc_acc, b);
        pay_count++;
        ticks = '0;
        return 1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus helpers
  function automatic feed_entry_t byte_row(input logic [7:0] b);
    feed_entry_t e;
    e = '0;
    e.it.cmd = CMD_BYTE;
    e.it.rx_byte = b;
    return e;
  endfunction

  function automatic feed_entry_t tick_row();
    feed_entry_t e;
    e = '0;
    e.it.cmd = CMD_TICK;
    e.it.rx_byte = 8'($urandom);
    return e;
  endfunction

  function automatic feed_entry_t expect_row(input feed_entry_t e, input out_item_t r);
    e.fixed = 1'b1;
    e.res = r;
    return e;
  endfunction

  function automatic void queue_in(input logic cmd, input logic [7:0] b);
    feed_entry_t e;
    e = '0;
    e.it.cmd = cmd;
    e.it.rx_byte = b;
    pending_items.push_back(e);
    phase_items++;
  endfunction

  function automatic int gap_ticks(input bit hunting);
    int lim;
    lim = hunting ? int'(m_silence_to) : int'(m_byte_to);
    return $urandom_range(1, (lim < 5) ? lim + 2 : 3);
  endfunction

  function automatic void queue_ticks(input int n);
    repeat (n) queue_in(CMD_TICK, 8'($urandom));
  endfunction

  // One frame; unless clean, it may be for another station, carry bad CRCs or be cut short.
  function automatic void queue_packet(input int len, input bit clean);
    logic [7:0] hdr [5];
    logic [7:0] body [$];
    logic [7:0] pcrc;
    int         nbytes, cut;
    hdr[1] = (clean || $urandom_range(0, 9) < 8) ? m_station : 8'($urandom);
    hdr[2] = 8'($urandom);
    hdr[3] = 8'($urandom);
    hdr[4] = len[7:0];
    hdr[0] = header_crc(hdr[1], hdr[2], hdr[3], hdr[4]);
    if (!clean && $urandom_range(0, 9) == 0) hdr[0] ^= 8'($urandom_range(1, 255));
    pcrc = 8'h00;
    for (int i = 0; i < len; i++) begin
      body.push_back(8'($urandom));
      pcrc = crc8_smbus(pcrc, body[i]);
    end
    if (!clean && $urandom_range(0, 4) == 0) pcrc ^= 8'($urandom_range(1, 255));
    nbytes = 6 + ((len != 0) ? len + 1 : 0);
    cut = (!clean && $urandom_range(0, 11) == 0) ? $urandom_range(1, nbytes - 1) : nbytes;
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(0, 9) == 0) queue_ticks(gap_ticks(i == 0));
      if (i == 0) queue_in(CMD_BYTE, START_BYTE);
      else if (i <= 5) queue_in(CMD_BYTE, hdr[i - 1]);
      else if (i == 6) queue_in(CMD_BYTE, pcrc);
      else queue_in(CMD_BYTE, body[i - 7]);
    end
  endfunction

  function automatic void queue_noise();
    repeat ($urandom_range(1, 8))
      queue_in(1'($urandom_range(0, 1)),
               ($urandom_range(0, 7) == 0) ? START_BYTE : 8'($urandom));
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) return 0;
    if (r < 17) return $urandom_range(1, 6);
    return $urandom_range(7, 40);
  endfunction

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_STATION_ID: m_station = val[7:0];
      REG_BYTE_TO:    m_byte_to = val[15:0];
      REG_SILENCE_TO: m_silence_to = val[15:0];
      default:        m_silence_en = val[0];
    endcase
  endtask

  task automatic configure(input logic [7:0] st, input logic [15:0] bto,
                           input logic [15:0] sto, input logic sen);
    reg_write(REG_STATION_ID, {24'h0, st});
    reg_write(REG_BYTE_TO, {16'h0, bto});
    reg_write(REG_SILENCE_TO, {16'h0, sto});
    reg_write(REG_SILENCE_EN, {31'h0, sen});
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- sender
  always @(posedge clk) begin
    feed_entry_t cur;
    out_item_t   pred;
    bit          due;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        cur = pending_items.pop_front();
        due = deframe_step(cur.it, pred);
        if (cur.fixed) expected_results.push_back(cur.res);
        else if (due) expected_results.push_back(pred);
      end
      if (!(item_valid && !item_ready)) begin
        if (send_gap != 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (pending_items.size() != 0 && send_idle_pct != 0 &&
                     $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(0, 13);
          item_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          item_valid <= 1'b1;
          item <= pending_items[0].it;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver and checker
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    logic      nxt_ready;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none actual %p", $time, result);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("kind", 8'(want.kind), 8'(result.kind));
        check_field("status", 8'(want.status), 8'(result.status));
        check_field("source_id", want.source_id, result.source_id);
        check_field("command", want.command, result.command);
        check_field("payload_len", want.payload_len, result.payload_len);
        check_field("payload_byte", want.payload_byte, result.payload_byte);
        check_field("payload_index", want.payload_index, result.payload_index);
      end
    end
    if (hold_seen != hold_ticket) begin
      hold_seen = hold_ticket;
      hold_left = LONG_HOLD;
    end
    if (rst) begin
      nxt_ready = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      nxt_ready = 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      nxt_ready = 1'b0;
    end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
      recv_gap = $urandom_range(0, 13);
      nxt_ready = 1'b0;
    end else begin
      nxt_ready = 1'b1;
    end
    result_ready <= nxt_ready;
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main sequence
  initial begin
    feed_entry_t directed_table[$];
    logic [7:0]  crc_bad, crc_foreign, crc_own, crc_pay;
    model_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // station 0xFF, zero timeouts so one tick expires them
    configure(8'hFF, 16'd0, 16'd0, 1'b1);
    crc_bad = header_crc(8'hFF, 8'h00, 8'hFF, 8'h00) ^ 8'h01;
    crc_foreign = header_crc(8'h00, 8'hAA, 8'h55, 8'h01);
    crc_own = header_crc(8'hFF, 8'hFF, 8'h00, 8'h01);
    crc_pay = crc8_smbus(8'h00, 8'hFF);
    directed_table = '{
      expect_row(tick_row(), status_result(ST_SILENCE, 8'h00, 8'h00, 8'h00)),
      byte_row(START_BYTE), byte_row(crc_bad), byte_row(8'hFF), byte_row(8'h00),
      byte_row(8'hFF),
      expect_row(byte_row(8'h00), status_result(ST_HDR_CRC, 8'h00, 8'h00, 8'h00)),
      // good CRC, other station: dropped without a transaction
      byte_row(START_BYTE), byte_row(crc_foreign), byte_row(8'h00), byte_row(8'hAA),
      byte_row(8'h55), byte_row(8'h01),
      byte_row(START_BYTE), byte_row(crc_own), byte_row(8'hFF), byte_row(8'hFF),
      byte_row(8'h00), byte_row(8'h01), byte_row(crc_pay),
      expect_row(byte_row(8'hFF), payload_result(8'hFF, 8'h00, 8'h01, 8'hFF, 8'h00)),
      // status flushed by the next start byte, which opens a new header
      expect_row(byte_row(START_BYTE), status_result(ST_OK, 8'hFF, 8'h00, 8'h01)),
      expect_row(tick_row(), status_result(ST_HDR_TO, 8'h00, 8'h00, 8'h00))
    };
    send_idle_pct = 20;
    recv_idle_pct = 20;
    foreach (directed_table[i]) pending_items.push_back(directed_table[i]);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure(8'h00, 16'd0, 16'd0, 1'b1);
        1: configure(8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
        default: configure(8'($urandom), 16'($urandom_range(0, 5)),
                           16'($urandom_range(0, 8)), 1'($urandom_range(0, 1)));
      endcase
      send_idle_pct = (p == PHASES - 1) ? 0 : 10 * (p % 4);
      recv_idle_pct = (p == PHASES - 1) ? 0 : 10 * ((p + 2) % 4);
      phase_items = 0;
      if (p == 1) queue_packet(255, 1'b1);
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 8) queue_packet(pick_len(), 1'b0);
        else queue_noise();
      end
      // flush a payload status still owed to the last frame
      queue_in(CMD_TICK, 8'($urandom));
      if (p == 2) hold_ticket++;
      wait_drained();
    end

    if (errors == 0 && expected_results.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
